/* rtl/cfra_pkg.sv */
// Shared types and constants for the continued fraction approximator.
package cfra_pkg;

    localparam int X_W   = 64;
    localparam int LIM_W = 32;
    localparam int MAG_W = 63;

    localparam logic [MAG_W-1:0] NUM_CAP = {MAG_W{1'b1}};
    localparam logic signed [X_W-1:0] NUM_POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [X_W-1:0] NUM_NEG_MAX = -64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [X_W-1:0] x_value;
        logic [LIM_W-1:0]      max_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [X_W-1:0] numerator;
        logic [LIM_W-1:0]      denominator;
        logic                  saturated;
    } t_out_item;

    typedef struct packed {
        logic kov;
        logic hov;
    } t_ovf_flags;

endpackage

/* rtl/cfra_step_unit.sv */
// One restoring divide step fused with MSB-first products of the quotient.
module cfra_step_unit #(
    parameter int W = 33
) (
    input  logic [W-1:0]                     i_rem,
    input  logic                             i_pbit,
    input  logic [W-1:0]                     i_q,
    input  logic [cfra_pkg::LIM_W-1:0]       i_kacc,
    input  logic [cfra_pkg::LIM_W-1:0]       i_k1,
    input  logic [cfra_pkg::LIM_W-1:0]       i_lim,
    input  logic [cfra_pkg::MAG_W-1:0]       i_hacc,
    input  logic [cfra_pkg::MAG_W-1:0]       i_h1,
    input  cfra_pkg::t_ovf_flags             i_flags,
    output logic [W-1:0]                     o_rem,
    output logic [cfra_pkg::LIM_W-1:0]       o_kacc,
    output logic [cfra_pkg::MAG_W-1:0]       o_hacc,
    output cfra_pkg::t_ovf_flags             o_flags
);
    import cfra_pkg::*;

    logic [W-1:0]       trial;
    logic               qbit;
    logic [LIM_W+1:0]   ksum;
    logic [MAG_W+1:0]   hsum;

    always_comb begin
        trial = {i_rem[W-2:0], i_pbit};
        qbit  = (trial >= i_q);
        o_rem = qbit ? (trial - i_q) : trial;

        ksum = {1'b0, i_kacc, 1'b0} + (qbit ? {2'b00, i_k1} : '0);
        hsum = {1'b0, i_hacc, 1'b0} + (qbit ? {2'b00, i_h1} : '0);

        o_kacc      = ksum[LIM_W-1:0];
        o_hacc      = hsum[MAG_W-1:0];
        o_flags.kov = i_flags.kov | (ksum > {2'b00, i_lim});
        o_flags.hov = i_flags.hov | (hsum[MAG_W+1:MAG_W] != 2'b00);
    end

endmodule

/* rtl/continued_fraction_rational_approx.sv */
// Top level: best rational approximation by continued fraction convergents.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | i_in_valid/o_in_stall   | x_value, max_denominator
//  out     | output    | o_out_valid/i_out_stall | numerator, denominator, sat
//
//  Each item passes S_IDLE, then per Euclid step after the integer part a
//  run of S_ITER over all W quotient bits and one S_CHECK, then S_DONE.
//  The step unit resolves one quotient bit per cycle, including both products.
//  Reset is synchronous and active low; it clears the sequencer and out valid.
//  The input stalls while an item is in work; the result waits in the output
//  register, and a new item is taken while it waits.
module continued_fraction_rational_approx #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cfra_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cfra_pkg::t_out_item  o_out_data
);
    import cfra_pkg::*;

    localparam int W     = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(W);
    localparam int INT_W = X_W - FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_CHECK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_neg;
    logic [LIM_W-1:0]    r_lim;
    logic [W-1:0]        r_p;
    logic [W-1:0]        r_q;
    logic [W-1:0]        r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAG_W-1:0]    r_h0;
    logic [MAG_W-1:0]    r_h1;
    logic [MAG_W-1:0]    r_hacc;
    logic [LIM_W-1:0]    r_k0;
    logic [LIM_W-1:0]    r_k1;
    logic [LIM_W-1:0]    r_kacc;
    logic                r_s0;
    logic                r_s1;
    t_ovf_flags          r_flags;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [W-1:0]        n_rem;
    logic [LIM_W-1:0]    n_kacc;
    logic [MAG_W-1:0]    n_hacc;
    t_ovf_flags          n_flags;

    logic                in_xfer;
    logic                out_free;
    logic [X_W-1:0]      mag;
    logic [INT_W-1:0]    int_part;
    logic [LIM_W:0]      k_tot;
    logic [MAG_W:0]      h_tot;
    logic                k_over;
    logic                h_ovf;
    logic [MAG_W-1:0]    h_next;

    cfra_step_unit #(
        .W(W)
    ) u_step (
        .i_rem   (r_rem),
        .i_pbit  (r_p[W-1]),
        .i_q     (r_q),
        .i_kacc  (r_kacc),
        .i_k1    (r_k1),
        .i_lim   (r_lim),
        .i_hacc  (r_hacc),
        .i_h1    (r_h1),
        .i_flags (r_flags),
        .o_rem   (n_rem),
        .o_kacc  (n_kacc),
        .o_hacc  (n_hacc),
        .o_flags (n_flags)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        mag      = i_in_data.x_value[X_W-1] ? (~i_in_data.x_value + 1'b1)
                                            : i_in_data.x_value;
        int_part = mag[X_W-1:FRAC_BITS];
        k_tot    = {1'b0, r_kacc} + {1'b0, r_k0};
        k_over   = r_flags.kov || (k_tot > {1'b0, r_lim});
        h_tot    = {1'b0, r_hacc} + {1'b0, r_h0};
        h_ovf    = r_flags.hov || h_tot[MAG_W];
        h_next   = h_ovf ? NUM_CAP : h_tot[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_neg   <= i_in_data.x_value[X_W-1];
                        r_lim   <= i_in_data.max_denominator;
                        r_s0    <= 1'b0;
                        r_s1    <= 1'b0;
                        r_p     <= W'(1) << FRAC_BITS;
                        r_q     <= {1'b0, mag[FRAC_BITS-1:0]};
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_hacc  <= '0;
                        r_kacc  <= '0;
                        r_flags <= '0;
                        if (i_in_data.max_denominator == '0) begin
                            r_h1    <= MAG_W'(1);
                            r_k1    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_h0 <= MAG_W'(1);
                            r_h1 <= MAG_W'(int_part);
                            r_k0 <= '0;
                            r_k1 <= LIM_W'(1);
                            if (mag[FRAC_BITS-1:0] == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ITER;
                            end
                        end
                    end
                end
                S_ITER: begin
                    r_rem   <= n_rem;
                    r_kacc  <= n_kacc;
                    r_hacc  <= n_hacc;
                    r_flags <= n_flags;
                    r_p     <= {r_p[W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (k_over) begin
                        r_state <= S_DONE;
                    end else begin
                        r_h0    <= r_h1;
                        r_h1    <= h_next;
                        r_s0    <= r_s1;
                        r_s1    <= r_s1 | h_ovf | r_s0;
                        r_k0    <= r_k1;
                        r_k1    <= k_tot[LIM_W-1:0];
                        r_p     <= r_q;
                        r_q     <= r_rem;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_hacc  <= '0;
                        r_kacc  <= '0;
                        r_flags <= '0;
                        if (r_rem == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ITER;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.numerator   <= r_neg ? -$signed({1'b0, r_h1})
                                                   : $signed({1'b0, r_h1});
                        r_out.denominator <= r_k1;
                        r_out.saturated   <= r_s1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/cfra_checker.sv */
// Port-level checks for the continued fraction approximator, bound to the top.
module cfra_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  cfra_pkg::t_in_item   i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  cfra_pkg::t_out_item  o_out_data
);
    import cfra_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid not cleared by reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled transfer changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            (o_out_data.numerator == NUM_POS_MAX) ||
            (o_out_data.numerator == NUM_NEG_MAX))
        else $error("saturated numerator not clamped");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.denominator == '0) |->
            (o_out_data.numerator == 64'sd1) || (o_out_data.numerator == -64'sd1))
        else $error("zero denominator without unit numerator");

endmodule

bind continued_fraction_rational_approx cfra_checker u_cfra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* verif/tb_continued_fraction_rational_approx.sv */
// Self-checking testbench for the continued fraction rational approximator.
module tb_continued_fraction_rational_approx;
    import cfra_pkg::*;

    localparam int FRAC_BITS   = 32;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 400;
    localparam int ITEM_WORST  = 2 + 48 * (FRAC_BITS + 2) + 2 * 13;
    localparam int DRAIN       = ITEM_WORST + 20;
    localparam int CYCLE_LIMIT = 3 * (N_DIRECTED + N_RANDOM + 1) * ITEM_WORST + 100;

    localparam logic [LIM_W-1:0]      LIM_MAX = 32'hFFFF_FFFF;
    localparam logic signed [X_W-1:0] X_ONE   = 64'sh1_0000_0000;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_directed_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_out_item expected_results[$];
    t_out_item want_now;
    int        mismatch_count = 0;
    int        results_seen   = 0;
    int        items_sent     = 0;
    int        cycle_count    = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{'{64'sd0, 32'd0}, 1'b1, '{64'sd1, 32'd0, 1'b0}},
        '{'{-64'sd1, 32'd0}, 1'b1, '{-64'sd1, 32'd0, 1'b0}},
        '{'{64'sd0, 32'd1}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{64'sd0, LIM_MAX}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{X_ONE, 32'd1}, 1'b1, '{64'sd1, 32'd1, 1'b0}},
        '{'{-X_ONE, 32'd1}, 1'b1, '{-64'sd1, 32'd1, 1'b0}},
        '{'{64'sh8000_0000, 32'd1}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{-64'sh8000_0000, 32'd1}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{64'sh8000_0000, 32'd2}, 1'b1, '{64'sd1, 32'd2, 1'b0}},
        '{'{64'sh8000_0000_0000_0000, LIM_MAX}, 1'b1,
          '{64'shFFFF_FFFF_8000_0000, 32'd1, 1'b0}},
        '{'{64'sh7FFF_FFFF_FFFF_FFFF, LIM_MAX}, 1'b0, '0},
        '{'{64'sh8000_0000_0000_0001, LIM_MAX}, 1'b0, '0},
        '{'{64'sd1, LIM_MAX}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{64'sd1, 32'd1}, 1'b1, '{64'sd0, 32'd1, 1'b0}},
        '{'{64'sd3, LIM_MAX}, 1'b0, '0},
        '{'{64'sh1_9E37_79B9, LIM_MAX}, 1'b0, '0},
        '{'{64'sh9E37_79B9, LIM_MAX}, 1'b0, '0},
        '{'{64'sh7FFF_FFFF_8000_0000, 32'd1}, 1'b0, '0},
        '{'{64'sh5_0000_0000, LIM_MAX}, 1'b1, '{64'sd5, 32'd1, 1'b0}},
        '{'{64'shFFFF_FFFD_C000_0000, 32'd4}, 1'b0, '0},
        '{'{64'sh3_243F_6A88, 32'd113}, 1'b0, '0},
        '{'{64'sh3_243F_6A88, 32'hFFFF}, 1'b0, '0},
        '{'{64'sh0_FFFF_FFFF, LIM_MAX}, 1'b0, '0},
        '{'{64'sh7FFF_FFFF_FFFF_FFFF, 32'd1}, 1'b0, '0}
    };

    continued_fraction_rational_approx #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item approx_convergent(t_in_item item);
        logic [63:0] cap, p, q, a, rem, lim, h0, h1, h2, k0, k1, k2;
        logic        neg, s0, s1, s2, done;
        t_out_item   res;
        cap  = {1'b0, NUM_CAP};
        neg  = item.x_value[X_W-1];
        p    = neg ? (~item.x_value + 64'd1) : item.x_value;
        q    = 64'd1 << FRAC_BITS;
        lim  = {32'd0, item.max_denominator};
        h0   = 64'd0;
        h1   = 64'd1;
        k0   = 64'd1;
        k1   = 64'd0;
        s0   = 1'b0;
        s1   = 1'b0;
        done = 1'b0;
        while (!done) begin
            a   = p / q;
            rem = p - a * q;
            s2  = s1;
            if (k1 == 64'd0) begin
                k2   = k0;
                done = k2 > lim;
            end else begin
                done = (k0 > lim) || (a > (lim - k0) / k1);
                k2   = a * k1 + k0;
            end
            if (!done) begin
                if (h0 > cap) begin
                    s2 = 1'b1;
                    h2 = cap;
                end else if (h1 == 64'd0) begin
                    h2 = h0;
                end else if (a > (cap - h0) / h1) begin
                    s2 = 1'b1;
                    h2 = cap;
                end else begin
                    h2 = a * h1 + h0;
                end
                if (s0) begin
                    s2 = 1'b1;
                end
                h0   = h1;
                s0   = s1;
                h1   = h2;
                s1   = s2;
                k0   = k1;
                k1   = k2;
                done = rem == 64'd0;
                p    = q;
                q    = rem;
            end
        end
        res.numerator   = neg ? (~h1 + 64'd1) : h1;
        res.denominator = k1[LIM_W-1:0];
        res.saturated   = s1;
        return res;
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        case ($urandom_range(0, 5))
            0, 1: begin
                item.x_value = {$urandom, $urandom};
            end
            2: begin
                item.x_value = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
            end
            3: begin
                item.x_value = $signed({$urandom, $urandom}) >>> $urandom_range(24, 40);
            end
            4: begin
                item.x_value = 64'($signed(16'($urandom))) <<< $urandom_range(24, 32);
            end
            default: begin
                item.x_value = $urandom_range(0, 1)
                    ? (NUM_POS_MAX - 64'($urandom_range(0, 1023)))
                    : (~NUM_POS_MAX + 64'($urandom_range(0, 1023)));
            end
        endcase
        case ($urandom_range(0, 5))
            0:       item.max_denominator = $urandom_range(0, 16);
            1:       item.max_denominator = $urandom_range(0, 65535);
            2, 3:    item.max_denominator = $urandom;
            4:       item.max_denominator = LIM_MAX - $urandom_range(0, 3);
            default: item.max_denominator = $urandom_range(0, 1);
        endcase
        return item;
    endfunction

    task automatic send_item(t_in_item item, logic typed, t_out_item want);
        int unsigned gap;
        gap = ((items_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(typed ? want : approx_convergent(item));
        items_sent++;
    endtask

    initial begin : out_side
        int unsigned hold;
        forever begin
            hold = ((results_seen / 30) % 3 == 2) ? 0 : $urandom_range(0, 12);
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected transfer: num %0d den %0d sat %0b",
                             o_out_data.numerator, o_out_data.denominator,
                             o_out_data.saturated);
                end
            end else begin
                want_now = expected_results.pop_front();
                if (o_out_data.numerator !== want_now.numerator
                        || o_out_data.denominator !== want_now.denominator
                        || o_out_data.saturated !== want_now.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp %0d/%0d sat %0b, got %0d/%0d sat %0b",
                                 want_now.numerator, want_now.denominator,
                                 want_now.saturated, o_out_data.numerator,
                                 o_out_data.denominator, o_out_data.saturated);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            send_item(random_item(), 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
